/* hdl/first_prime_in_stream_macros.svh */
// assertion macros for the first_prime_in_stream block
`ifndef FIRST_PRIME_IN_STREAM_MACROS_SVH
`define FIRST_PRIME_IN_STREAM_MACROS_SVH

`ifndef SYNTHESIS

// condition holds, consequence holds in the same cycle
`define FPIS_ASSERT_SAME(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// condition holds, consequence holds in the next cycle
`define FPIS_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`else

`define FPIS_ASSERT_SAME(lbl, clk, rst, cond, cons)
`define FPIS_ASSERT_NEXT(lbl, clk, rst, cond, cons)

`endif

`endif

/* hdl/fpis_pkg.sv */
// shared constants and types for the first_prime_in_stream block
`default_nettype none

package fpis_pkg;

   localparam int VALUE_BITS_DEF = 16;

   // status of the shared remainder unit
   typedef struct packed {
      logic busy;
      logic done;
   } rem_sts_type;

endpackage

`default_nettype wire

/* hdl/fpis_rem_unit.sv */
// bit-serial restoring remainder unit, one quotient bit per cycle
`default_nettype none

module fpis_rem_unit #(
   parameter int VALUE_BITS = fpis_pkg::VALUE_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [VALUE_BITS-1:0]   dividend,
   input  wire logic [VALUE_BITS-1:0]   divisor,
   output fpis_pkg::rem_sts_type        sts,
   output logic      [VALUE_BITS-1:0]   remainder
);

   localparam int CNT_BITS = $clog2(VALUE_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] dvd_ff, dvd_in;
   logic [VALUE_BITS-1:0] dsr_ff, dsr_in;
   logic [VALUE_BITS:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, dvd_ff[VALUE_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so it fits back
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = VALUE_BITS'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = VALUE_BITS'(trial);
         end
         dvd_in = {dvd_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* hdl/first_prime_in_stream.sv */
// top level: first prime of each run by trial division over a shared remainder unit
// one item at a time; a beat is taken only in idle, the result loads at the end of its last cycle
// non-candidates (below 2, negative, or after a reported prime) go from idle straight to finish
// a prime n needs one remainder per divisor, for every divisor from 2 up to floor(sqrt(n))
// a composite stops at p, its least divisor; a stalled result holds finish; synchronous reset
// clears the sequencer, the run flag and the output valid flag
`default_nettype none
`include "first_prime_in_stream_macros.svh"

module first_prime_in_stream #(
   parameter int VALUE_BITS = fpis_pkg::VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   input  wire logic                         req_last,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed      [VALUE_BITS-1:0] rsp_prime_found
);

   localparam int SQ_BITS = VALUE_BITS + 2;
   localparam logic [VALUE_BITS-1:0] FIRST_DIV = VALUE_BITS'(2);
   localparam logic [SQ_BITS-1:0]    FIRST_SQ  = SQ_BITS'(4);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_START  = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_BITS-1:0]  n_ff, n_in;
   logic                   last_ff, last_in;
   logic                   rep_ff, rep_in;
   logic                   prime_ff, prime_in;
   logic [VALUE_BITS-1:0]  d_ff, d_in;
   logic [SQ_BITS-1:0]     sq_ff, sq_in;
   logic                   out_valid_ff, out_valid_in;
   logic signed [VALUE_BITS-1:0] out_data_ff, out_data_in;

   logic                   rem_start;
   fpis_pkg::rem_sts_type  rem_sts;
   logic [VALUE_BITS-1:0]  rem_value;
   logic                   out_free;
   logic                   emit;

   fpis_rem_unit #(
      .VALUE_BITS (VALUE_BITS)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .sts       (rem_sts),
      .remainder (rem_value)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit     = !rep_ff && (prime_ff || last_ff);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      last_in      = last_ff;
      rep_in       = rep_ff;
      prime_in     = prime_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      rem_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in     = $unsigned(req_value);
               last_in  = req_last;
               prime_in = 1'b0;
               d_in     = FIRST_DIV;
               sq_in    = FIRST_SQ;
               if (rep_ff || req_value[VALUE_BITS-1] || ($unsigned(req_value) < FIRST_DIV)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            // no divisor up to sqrt(n) divides it
            if (sq_ff > {2'b00, n_ff}) begin
               prime_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               rem_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (rem_sts.done) begin
               if (rem_value == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  d_in     = d_ff + VALUE_BITS'(1);
                  sq_in    = sq_ff + SQ_BITS'({d_ff, 1'b1});
                  state_in = ST_START;
               end
            end
         end
         ST_FINISH: begin
            if (!emit || out_free) begin
               if (emit) begin
                  out_valid_in = 1'b1;
                  out_data_in  = prime_ff ? $signed(n_ff) : '1;
               end
               rep_in   = last_ff ? 1'b0 : (rep_ff || prime_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rep_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rep_ff       <= rep_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff        <= n_in;
      last_ff     <= last_in;
      prime_ff    <= prime_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      out_data_ff <= out_data_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_prime_found = out_data_ff;

   `FPIS_ASSERT_SAME(a_wait_has_unit, clock, reset, state_ff == ST_WAIT,
                     rem_sts.busy || rem_sts.done)
   `FPIS_ASSERT_SAME(a_start_when_free, clock, reset, rem_start,
                     !rem_sts.busy && !rem_sts.done)
   `FPIS_ASSERT_NEXT(a_reported_skips, clock, reset, req_valid && !req_stall && rep_ff,
                     state_ff == ST_FINISH && !prime_ff)
   `FPIS_ASSERT_SAME(a_rsp_range, clock, reset, rsp_valid,
                     !rsp_prime_found[VALUE_BITS-1] || (rsp_prime_found == '1))

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for first_prime_in_stream: directed runs, random runs, random idling
`timescale 1ns / 1ps

module tb_top;

   localparam int VB = fpis_pkg::VALUE_BITS_DEF;
   localparam int MAX_IDLE = 18;
   // a 15-bit prime walks about 180 divisors, plus both idles
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 4000;
   localparam logic signed [VB-1:0] NO_PRIME = -1;

   typedef struct {
      logic signed [VB-1:0] value;
      logic                 last;
   } run_elem_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [VB-1:0] req_value = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [VB-1:0] rsp_prime_found;

   run_elem_type elems_to_send[$];
   logic signed [VB-1:0] expected_primes[$];
   bit prime_seen_in_run = 1'b0;
   int error_count = 0;

   int unsigned req_hold = 0;
   int unsigned rsp_hold = 0;
   int unsigned beats_in = 0;
   int unsigned beats_out = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   bit beat_taken;

   first_prime_in_stream uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_found (rsp_prime_found)
   );

   always #2 clock = ~clock;

   function automatic bit value_is_prime(logic signed [VB-1:0] v);
      int n;
      n = v;
      if (n < 2) return 1'b0;
      for (int d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // first prime of a run goes out, a run ending with none gives all ones
   function automatic void predict_first_prime(logic signed [VB-1:0] v, logic l);
      if (!prime_seen_in_run && value_is_prime(v)) begin
         expected_primes.push_back(v);
         prime_seen_in_run = 1'b1;
      end
      if (l) begin
         if (!prime_seen_in_run) expected_primes.push_back(NO_PRIME);
         prime_seen_in_run = 1'b0;
      end
   endfunction

   function automatic int unsigned draw_idle(bit burst);
      return burst ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   function automatic logic signed [VB-1:0] draw_value();
      logic signed [VB-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = VB'($urandom_range(0, 200));
         3:       v = VB'($urandom_range(0, 3));
         4:       v = {1'b1, 15'($urandom)};
         default: v = VB'($urandom);
      endcase
      return v;
   endfunction

   function automatic void add_elem(logic signed [VB-1:0] v, logic l);
      run_elem_type e;
      e.value = v;
      e.last = l;
      elems_to_send.push_back(e);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_hold = draw_idle(1'b0);
      end else begin
         beat_taken = req_valid && !req_stall;
         if (beat_taken) begin
            predict_first_prime(req_value, req_last);
            void'(elems_to_send.pop_front());
            beats_in++;
            if (beats_in % 23 == 0) req_burst = ~req_burst;
            req_hold = draw_idle(req_burst);
         end
         if (!req_valid || beat_taken) begin
            if (req_hold > 0) begin
               req_hold--;
               req_valid <= 1'b0;
            end else if (elems_to_send.size() > 0) begin
               req_valid <= 1'b1;
               req_value <= elems_to_send[0].value;
               req_last <= elems_to_send[0].last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: stall rises ahead of a result and counts down only while one is offered
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = draw_idle(1'b0);
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_primes.size() == 0) begin
               $display("%0t: unexpected beat, prime_found %0d", $time, rsp_prime_found);
               error_count++;
            end else begin
               if (rsp_prime_found !== expected_primes[0]) begin
                  $display("%0t: prime_found expected %0d actual %0d",
                           $time, expected_primes[0], rsp_prime_found);
                  error_count++;
               end
               void'(expected_primes.pop_front());
            end
            beats_out++;
            if (beats_out % 9 == 0) rsp_burst = ~rsp_burst;
            rsp_hold = draw_idle(rsp_burst);
         end else if (rsp_valid && rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold > 0);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("first_prime_in_stream regression: fail");
      $finish;
   end

   initial begin : stimulus
      int unsigned rand_elems;
      int unsigned rand_runs;
      int unsigned run_len;

      // single-element runs
      add_elem(16'sd2, 1'b1);
      add_elem(16'sd1, 1'b1);
      add_elem(16'sd0, 1'b1);
      // no prime at all: field extremes and negatives
      add_elem(-16'sd32768, 1'b0);
      add_elem(-16'sd1, 1'b0);
      add_elem(16'sd4, 1'b0);
      add_elem(16'sd32767, 1'b1);
      // largest prime, on the last element
      add_elem(16'sd32749, 1'b1);
      // primes after the first one are dropped
      add_elem(16'sd9, 1'b0);
      add_elem(16'sd3, 1'b0);
      add_elem(16'sd5, 1'b0);
      add_elem(16'sd7, 1'b1);
      add_elem(16'sd4, 1'b0);
      add_elem(16'sd32749, 1'b0);
      add_elem(16'sd6, 1'b1);
      // squares of primes, then a run of one prime
      add_elem(16'sd25, 1'b0);
      add_elem(16'sd49, 1'b1);
      add_elem(16'sd3, 1'b1);

      rand_elems = 0;
      rand_runs = 0;
      while (rand_elems < 122 || rand_runs < 30) begin
         run_len = $urandom_range(1, 6);
         for (int i = 0; i < run_len; i++) begin
            add_elem(draw_value(), i == run_len - 1);
         end
         rand_elems += run_len;
         rand_runs++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (elems_to_send.size() > 0 || req_valid || expected_primes.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("first_prime_in_stream regression: pass");
      end else begin
         $display("first_prime_in_stream regression: fail");
      end
      $finish;
   end

endmodule
